### hdl/assert_macros.svh
// assertion macros shared by the interpolator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLY(lbl, ck, rn, ante, cons)
`define ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

### hdl/pli_pkg.sv
// shared constants and types of the interpolator
package pli_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int DATA_W      = 32;
    localparam int CNT_W       = 5;
    localparam int STEP_W      = $clog2(DATA_W);

    // request opcodes carried on the operation port
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        REG_WRITE  = 3'd0,
        REG_LOW    = 3'd1,
        REG_INTERP = 3'd2,
        REG_HIGH   = 3'd3,
        REG_BAD    = 3'd4
    } region_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

### hdl/pli_table.sv
// breakpoint storage, one write and one registered read port
module pli_table
(
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [pli_pkg::IDX_W-1:0]             wr_addr,
    input  logic [pli_pkg::DATA_W-1:0]            wr_x,
    input  logic [pli_pkg::DATA_W-1:0]            wr_y,
    input  logic [pli_pkg::IDX_W-1:0]             rd_addr,
    output logic [pli_pkg::DATA_W-1:0]            rd_x,
    output logic [pli_pkg::DATA_W-1:0]            rd_y
);

    logic [pli_pkg::DATA_W-1:0] x_mem [pli_pkg::TABLE_DEPTH];
    logic [pli_pkg::DATA_W-1:0] y_mem [pli_pkg::TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            x_mem[wr_addr] <= wr_x;
            y_mem[wr_addr] <= wr_y;
        end
        rd_x <= x_mem[rd_addr];
        rd_y <= y_mem[rd_addr];
    end

endmodule

### hdl/pli_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
module pli_mul
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [pli_pkg::DATA_W-1:0]            a,
    input  logic [pli_pkg::DATA_W-1:0]            b,
    output pli_pkg::unit_stat_t                   stat,
    output logic [2*pli_pkg::DATA_W-1:0]          product
);

    logic [pli_pkg::DATA_W-1:0] a_reg, hi_reg, lo_reg, hi_next, lo_next;
    logic [pli_pkg::STEP_W-1:0] cnt_reg, cnt_next;
    logic                       run_reg, run_next, done_reg, done_next;
    logic [pli_pkg::DATA_W:0]   sum;

    always_comb
    begin
        sum       = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            hi_next  = '0;
            lo_next  = b;
            cnt_next = pli_pkg::STEP_W'(pli_pkg::DATA_W - 1);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            // add partial product, then shift the pair right one bit
            hi_next = sum[pli_pkg::DATA_W:1];
            lo_next = {sum[0], lo_reg[pli_pkg::DATA_W-1:1]};
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
        end
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign stat.busy = run_reg;
    assign stat.done = done_reg;
    assign product   = {hi_reg, lo_reg};

endmodule

### hdl/pli_div.sv
// restoring divider, one quotient bit per cycle
module pli_div
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [2*pli_pkg::DATA_W-1:0]          dividend,
    input  logic [pli_pkg::DATA_W-1:0]            divisor,
    output pli_pkg::unit_stat_t                   stat,
    output logic [pli_pkg::DATA_W-1:0]            quotient
);

    logic [pli_pkg::DATA_W-1:0] den_reg, rem_reg, quo_reg, rem_next, quo_next;
    logic [pli_pkg::STEP_W-1:0] cnt_reg, cnt_next;
    logic                       run_reg, run_next, done_reg, done_next;
    logic [pli_pkg::DATA_W:0]   trial;
    logic [pli_pkg::DATA_W+1:0] diff;
    logic                       fits;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[pli_pkg::DATA_W-1]};
        diff      = {1'b0, trial} - {2'b00, den_reg};
        fits      = !diff[pli_pkg::DATA_W+1];
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            // upper half must be below the divisor for the quotient to fit one word; this block does not enforce it
            rem_next = dividend[2*pli_pkg::DATA_W-1:pli_pkg::DATA_W];
            quo_next = dividend[pli_pkg::DATA_W-1:0];
            cnt_next = pli_pkg::STEP_W'(pli_pkg::DATA_W - 1);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = fits ? diff[pli_pkg::DATA_W-1:0] : trial[pli_pkg::DATA_W-1:0];
            quo_next = {quo_reg[pli_pkg::DATA_W-2:0], fits};
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= divisor;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign stat.busy = run_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

### hdl/piecewise_linear_interpolator.sv
// top level: breakpoint table, scan sequencer and serial interpolation datapath
//
//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+-------------------------------------------
//  request   | in        | start high, busy low   | operation, point_index, point_x/y, query_x
//  result    | out       | done, one cycle        | value, region
//  config    | in        | cfg_valid & cfg_ready  | cfg_data (point count)
//
// a write request stores its breakpoint at the accept edge; its result shows the next cycle
// a query scans each breakpoint with a registered table read, then a compare
// an interpolated query adds prep, multiply, divide and sum states after the scan
//   (each serial unit runs 32 bit steps, then strobes done)
// the serial multiplier and divider, one bit per cycle, set the interpolation time
// rst_n clears the sequencer and point count (to 1); table contents stay undefined
// done is a one-cycle strobe; the receiver cannot stall, busy is the only back pressure
`include "assert_macros.svh"

module piecewise_linear_interpolator
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // request channel
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  operation,
    input  logic [3:0]                            point_index,
    input  logic signed [31:0]                    point_x,
    input  logic signed [31:0]                    point_y,
    input  logic signed [31:0]                    query_x,
    // result channel
    output logic                                  done,
    output logic signed [31:0]                    value,
    output logic [2:0]                            region,
    // configuration channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [pli_pkg::CNT_W-1:0]             cfg_data
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_READ = 7'b0000010,
        ST_CMP  = 7'b0000100,
        ST_PREP = 7'b0001000,
        ST_MUL  = 7'b0010000,
        ST_DIV  = 7'b0100000,
        ST_SUM  = 7'b1000000
    } state_t;

    localparam int DW = pli_pkg::DATA_W;
    localparam int IW = pli_pkg::IDX_W;

    state_t                    state_reg, state_next;
    logic [pli_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [IW-1:0]             k_reg, k_next, last_reg, last_next;
    logic                      done_reg, done_next;
    pli_pkg::region_t          region_reg, region_next;
    logic [DW-1:0]             value_reg, value_next;
    logic [DW-1:0]             q_reg, q_next, x0_reg, x0_next, y0_reg, y0_next;
    logic [DW-1:0]             den_reg, den_next;
    logic                      neg_reg, neg_next;

    // request decode
    logic                      req_accept, req_write, wr_ok, wr_en;
    logic [IW-1:0]             wr_addr, last_idx;

    // table read port
    logic [DW-1:0]             rd_x, rd_y;

    // segment prep
    logic [DW:0]               den_c, dx_c;
    logic                      y_up;
    logic [DW-1:0]             mag_c;
    logic                      den_pos;

    // serial units
    logic                      mul_start, div_start;
    pli_pkg::unit_stat_t       mul_stat, div_stat;
    logic [2*DW-1:0]           mul_prod;
    logic [DW-1:0]             div_quo;

    // final sum and saturation
    logic [DW+1:0]             res_c;
    logic [DW-1:0]             sat_c;

    assign req_accept = start && !busy;
    assign req_write  = req_accept && (operation == pli_pkg::OP_WRITE);
    assign wr_ok      = 32'(point_index) < pli_pkg::TABLE_DEPTH;
    assign wr_en      = req_write && wr_ok;
    assign wr_addr    = IW'(point_index);

    // count in use, clamped to the table (zero acts as one); kept as the last index to scan
    always_comb
    begin
        if (cnt_reg == '0)
        begin
            last_idx = '0;
        end
        else if (32'(cnt_reg) > pli_pkg::TABLE_DEPTH)
        begin
            last_idx = IW'(pli_pkg::TABLE_DEPTH - 1);
        end
        else
        begin
            last_idx = IW'(cnt_reg - 1'b1);
        end
    end

    pli_table u_table
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_x    (point_x),
        .wr_y    (point_y),
        .rd_addr (k_reg),
        .rd_x    (rd_x),
        .rd_y    (rd_y)
    );

    // segment from (x0, y0) held in registers to (x1, y1) still on the read port
    always_comb
    begin
        den_c   = {rd_x[DW-1], rd_x} - {x0_reg[DW-1], x0_reg};
        dx_c    = {q_reg[DW-1], q_reg} - {x0_reg[DW-1], x0_reg};
        den_pos = !den_c[DW] && (den_c[DW-1:0] != '0);
        y_up    = $signed(rd_y) >= $signed(y0_reg);
        mag_c   = y_up ? (rd_y - y0_reg) : (y0_reg - rd_y);
    end

    assign mul_start = (state_reg == ST_PREP) && den_pos;
    assign div_start = (state_reg == ST_MUL) && mul_stat.done;

    pli_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mag_c),
        .b       (dx_c[DW-1:0]),
        .stat    (mul_stat),
        .product (mul_prod)
    );

    pli_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mul_prod),
        .divisor  (den_reg),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    // y0 plus or minus the quotient, saturated to one word
    always_comb
    begin
        res_c = neg_reg ? ({{2{y0_reg[DW-1]}}, y0_reg} - {2'b00, div_quo})
                        : ({{2{y0_reg[DW-1]}}, y0_reg} + {2'b00, div_quo});
        if ((res_c[DW+1] == res_c[DW]) && (res_c[DW] == res_c[DW-1]))
        begin
            sat_c = res_c[DW-1:0];
        end
        else if (res_c[DW+1])
        begin
            sat_c = {1'b1, {(DW-1){1'b0}}};
        end
        else
        begin
            sat_c = {1'b0, {(DW-1){1'b1}}};
        end
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        k_next      = k_reg;
        last_next   = last_reg;
        done_next   = 1'b0;
        region_next = region_reg;
        value_next  = value_reg;
        q_next      = q_reg;
        x0_next     = x0_reg;
        y0_next     = y0_reg;
        den_next    = den_reg;
        neg_next    = neg_reg;

        if (cfg_valid && cfg_ready)
        begin
            cnt_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    if (operation == pli_pkg::OP_WRITE)
                    begin
                        // write finishes without leaving idle
                        done_next   = 1'b1;
                        value_next  = '0;
                        region_next = pli_pkg::REG_WRITE;
                    end
                    else
                    begin
                        q_next     = query_x;
                        k_next     = '0;
                        last_next  = last_idx;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if ($signed(q_reg) <= $signed(rd_x))
                begin
                    if (k_reg == '0)
                    begin
                        done_next   = 1'b1;
                        value_next  = rd_y;
                        region_next = pli_pkg::REG_LOW;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_PREP;
                    end
                end
                else if (k_reg == last_reg)
                begin
                    done_next   = 1'b1;
                    value_next  = rd_y;
                    region_next = pli_pkg::REG_HIGH;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    // remember this entry as the left end of the next segment
                    x0_next    = rd_x;
                    y0_next    = rd_y;
                    k_next     = k_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_PREP:
            begin
                if (den_pos)
                begin
                    den_next   = den_c[DW-1:0];
                    neg_next   = !y_up;
                    state_next = ST_MUL;
                end
                else
                begin
                    done_next   = 1'b1;
                    value_next  = y0_reg;
                    region_next = pli_pkg::REG_BAD;
                    state_next  = ST_IDLE;
                end
            end
            ST_MUL:
            begin
                if (mul_stat.done)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                done_next   = 1'b1;
                value_next  = sat_c;
                region_next = pli_pkg::REG_INTERP;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= pli_pkg::CNT_W'(1);
            k_reg      <= '0;
            last_reg   <= '0;
            done_reg   <= 1'b0;
            region_reg <= pli_pkg::REG_WRITE;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            k_reg      <= k_next;
            last_reg   <= last_next;
            done_reg   <= done_next;
            region_reg <= region_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        q_reg     <= q_next;
        x0_reg    <= x0_next;
        y0_reg    <= y0_next;
        den_reg   <= den_next;
        neg_reg   <= neg_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign value     = value_reg;
    assign region    = region_reg;

    // a query request always leaves idle
    `ASSERT_NEXT(a_query_busy, clk, rst_n, req_accept && (operation == pli_pkg::OP_QUERY), busy)
    // a write request answers on the next cycle with a cleared value
    `ASSERT_NEXT(a_write_done, clk, rst_n, req_write, done && (region == pli_pkg::REG_WRITE) && (value == '0))
    // every result is given back in idle
    `ASSERT_IMPLY(a_done_idle, clk, rst_n, done, !busy)
    // multiplier finishes only while the sequencer waits for it
    `ASSERT_IMPLY(a_mul_owned, clk, rst_n, mul_stat.done, state_reg == ST_MUL)
    // divider is never started while the multiplier still runs
    `ASSERT_IMPLY(a_div_order, clk, rst_n, div_start, !mul_stat.busy)
    // divider runs only while the sequencer waits for it
    `ASSERT_IMPLY(a_div_owned, clk, rst_n, div_stat.busy, state_reg == ST_DIV)

endmodule
